FILE: sv/lftmf_pkg.sv
package lftmf_pkg;

    // Input item kinds
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    localparam int SYNC_PAIRS = 9;
    localparam int DATA_BITS  = 8;
    localparam int ID_WIDTH   = 16;

    // Sync pattern as chip pairs: bit 1 = first chip, bit 0 = second chip
    localparam logic [1:0] SYNC_TABLE [SYNC_PAIRS] = '{
        2'b11, 2'b10, 2'b00, 2'b10, 2'b11, 2'b00, 2'b11, 2'b00, 2'b10
    };

    // One chip pair held by a cell
    typedef struct packed {
        logic valid;
        logic first_chip;
        logic second_chip;
        logic run_last;
        logic telegram_done;
    } pair_t;

    // Manchester code of one bit: one is chips 0 then 1, zero is 1 then 0
    function automatic logic [1:0] manchester(input logic bit_value);
        return bit_value ? 2'b01 : 2'b10;
    endfunction

endpackage

FILE: sv/lftmf_in_if.sv
interface lftmf_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] sensor_id;
    logic [7:0]  payload_byte;
    logic        ends_telegram;

    modport source (
        output valid, kind, sensor_id, payload_byte, ends_telegram,
        input  ready
    );
    modport sink (
        input  valid, kind, sensor_id, payload_byte, ends_telegram,
        output ready
    );
endinterface

FILE: sv/lftmf_out_if.sv
interface lftmf_out_if;
    logic valid;
    logic ready;
    logic first_chip;
    logic second_chip;
    logic run_last;
    logic telegram_done;

    modport source (
        output valid, first_chip, second_chip, run_last, telegram_done,
        input  ready
    );
    modport sink (
        input  valid, first_chip, second_chip, run_last, telegram_done,
        output ready
    );
endinterface

FILE: sv/lftmf_frame_gen.sv
module lftmf_frame_gen
    import lftmf_pkg::*;
#(
    parameter int PREAMBLE_BITS = 16,
    parameter int ID_BITS = 16,
    localparam int NumCells = PREAMBLE_BITS + SYNC_PAIRS + ID_BITS
)
(
    input  logic                kind,
    input  logic [ID_WIDTH-1:0] sensor_id,
    input  logic [7:0]          payload_byte,
    input  logic                ends_telegram,
    output pair_t               pairs [NumCells]
);

    // Per-cell load value: each cell gets its own fixed slot of the frame
    for (genvar i = 0; i < NumCells; i++) begin : g_slot
        logic [1:0] hdr_chips;
        logic [1:0] dat_chips;
        logic       hdr_last;
        logic       dat_last;
        logic       dat_valid;

        if (i < PREAMBLE_BITS) begin : g_pre
            assign hdr_chips = manchester(1'b0);
        end
        else if (i < PREAMBLE_BITS + SYNC_PAIRS) begin : g_sync
            assign hdr_chips = SYNC_TABLE[i - PREAMBLE_BITS];
        end
        else begin : g_id
            assign hdr_chips =
                manchester(sensor_id[ID_BITS - 1 - (i - PREAMBLE_BITS - SYNC_PAIRS)]);
        end

        if (i < DATA_BITS) begin : g_dat
            assign dat_chips = manchester(payload_byte[DATA_BITS - 1 - i]);
            assign dat_valid = 1'b1;
        end
        else begin : g_nodat
            assign dat_chips = 2'b00;
            assign dat_valid = 1'b0;
        end

        assign hdr_last = (i == NumCells - 1);
        assign dat_last = (i == DATA_BITS - 1);

        always_comb
        begin
            if (kind == KIND_HEADER)
            begin
                pairs[i].valid         = 1'b1;
                pairs[i].first_chip    = hdr_chips[1];
                pairs[i].second_chip   = hdr_chips[0];
                pairs[i].run_last      = hdr_last;
                pairs[i].telegram_done = hdr_last & ends_telegram;
            end
            else
            begin
                pairs[i].valid         = dat_valid;
                pairs[i].first_chip    = dat_chips[1];
                pairs[i].second_chip   = dat_chips[0];
                pairs[i].run_last      = dat_last;
                pairs[i].telegram_done = dat_last & ends_telegram;
            end
        end
    end

endmodule

FILE: sv/lftmf_cell.sv
module lftmf_cell
    import lftmf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  logic  shift,
    input  pair_t load_pair,
    input  pair_t next_pair,
    output pair_t cell_pair
);

    pair_t pair_reg;
    pair_t pair_next;

    // Load a new frame slot, or take the neighbor's pair on a shift
    always_comb
    begin
        if (load)
        begin
            pair_next = load_pair;
        end
        else if (shift)
        begin
            pair_next = next_pair;
        end
        else
        begin
            pair_next = pair_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_reg <= '0;
        end
        else
        begin
            pair_reg <= pair_next;
        end
    end

    assign cell_pair = pair_reg;

endmodule

FILE: sv/lf_telegram_manchester_framer_top.sv
// Channel    Modport  Payload                                          Transfer
// frame_in   sink     kind, sensor_id, payload_byte, ends_telegram     valid & ready
// pair_out   source   first_chip, second_chip, run_last, telegram_done valid & ready
//
// An accepted item loads its whole frame into a row of cells in parallel;
// the row shifts toward cell 0, which drives pair_out, one pair per cycle.
// A header is PREAMBLE_BITS + 9 + ID_BITS pairs (41 by default), a data
// byte 8 pairs; the next item is taken on the edge where the last pair leaves.
// A stall on pair_out freezes the row. Reset empties all cells.
module lf_telegram_manchester_framer_top
    import lftmf_pkg::*;
#(
    parameter int PREAMBLE_BITS = 16,
    parameter int ID_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    lftmf_in_if.sink    frame_in,
    lftmf_out_if.source pair_out
);

    localparam int NumCells = PREAMBLE_BITS + SYNC_PAIRS + ID_BITS;

    pair_t load_pairs [NumCells];
    pair_t cells      [NumCells];
    logic  shift;
    logic  load;

    // Frame slot generation
    lftmf_frame_gen #(
        .PREAMBLE_BITS (PREAMBLE_BITS),
        .ID_BITS       (ID_BITS)
    ) u_frame_gen (
        .kind          (frame_in.kind),
        .sensor_id     (frame_in.sensor_id),
        .payload_byte  (frame_in.payload_byte),
        .ends_telegram (frame_in.ends_telegram),
        .pairs         (load_pairs)
    );

    // Row advances whenever the head is empty or being taken
    assign shift = !cells[0].valid || pair_out.ready;
    assign frame_in.ready = !cells[1].valid && shift;
    assign load = frame_in.valid && frame_in.ready;

    // Row of cells, cell 0 at the output
    for (genvar i = 0; i < NumCells; i++) begin : g_cell
        pair_t neighbor;

        if (i == NumCells - 1) begin : g_tail
            assign neighbor = '0;
        end
        else begin : g_mid
            assign neighbor = cells[i + 1];
        end

        lftmf_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .load      (load),
            .shift     (shift),
            .load_pair (load_pairs[i]),
            .next_pair (neighbor),
            .cell_pair (cells[i])
        );
    end

    // Output from the head cell
    assign pair_out.valid         = cells[0].valid;
    assign pair_out.first_chip    = cells[0].first_chip;
    assign pair_out.second_chip   = cells[0].second_chip;
    assign pair_out.run_last      = cells[0].run_last;
    assign pair_out.telegram_done = cells[0].telegram_done;

endmodule

FILE: sim/tb_lf_telegram_manchester_framer_top.sv
`timescale 1ns / 1ps

module tb_lf_telegram_manchester_framer_top;
    import lftmf_pkg::*;

    localparam int PREAMBLE_BITS  = 16;
    localparam int ID_BITS        = 16;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int TAIL_CYCLES    = 60;
    localparam int HOLD_OFF_CYCLES = 400;

    // Sync chips, first pair in the top two bits: 11,10,00,10,11,00,11,00,10
    localparam logic [17:0] SYNC_CHIPS = 18'b11_10_00_10_11_00_11_00_10;

    typedef struct {
        logic        kind;
        logic [15:0] sensor_id;
        logic [7:0]  payload_byte;
        logic        ends_telegram;
    } frame_item_t;

    typedef struct packed {
        logic first_chip;
        logic second_chip;
        logic run_last;
        logic telegram_done;
    } chip_pair_t;

    logic clk;
    logic rst_n;

    lftmf_in_if  frame_in_bus ();
    lftmf_out_if pair_out_bus ();

    lf_telegram_manchester_framer_top #(
        .PREAMBLE_BITS (PREAMBLE_BITS),
        .ID_BITS       (ID_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame_in (frame_in_bus),
        .pair_out (pair_out_bus)
    );

    frame_item_t frames_to_send [$];
    chip_pair_t  expected_pairs [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int cycle_count    = 0;
    int items_accepted = 0;
    int headers_accepted = 0;
    int pairs_checked  = 0;
    int telegrams_done = 0;
    int mismatches     = 0;

    // Clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Manchester code of one bit as a plain chip pair
    function automatic chip_pair_t coded_bit(input logic bit_value);
        chip_pair_t p;
        p = '0;
        p.first_chip  = ~bit_value;
        p.second_chip = bit_value;
        return p;
    endfunction

    // Expected chip pairs for one accepted frame item
    task automatic frame_telegram_item(input frame_item_t item);
        chip_pair_t run [$];
        chip_pair_t p;
        int k;
        if (item.kind == KIND_HEADER)
        begin
            for (k = 0; k < PREAMBLE_BITS; k++)
                run.push_back(coded_bit(1'b0));
            for (k = 0; k < 9; k++)
            begin
                p = '0;
                p.first_chip  = SYNC_CHIPS[17 - 2 * k];
                p.second_chip = SYNC_CHIPS[16 - 2 * k];
                run.push_back(p);
            end
            for (k = ID_BITS - 1; k >= 0; k--)
                run.push_back(coded_bit(item.sensor_id[k]));
        end
        else
        begin
            for (k = DATA_BITS - 1; k >= 0; k--)
                run.push_back(coded_bit(item.payload_byte[k]));
        end
        run[run.size() - 1].run_last      = 1'b1;
        run[run.size() - 1].telegram_done = item.ends_telegram;
        foreach (run[i])
            expected_pairs.push_back(run[i]);
    endtask

    task automatic queue_item(input logic kind, input logic [15:0] id,
                              input logic [7:0] data_byte, input logic ends);
        frame_item_t item;
        item.kind          = kind;
        item.sensor_id     = id;
        item.payload_byte  = data_byte;
        item.ends_telegram = ends;
        frames_to_send.push_back(item);
    endtask

    // Mostly well-formed telegrams (header, 0..6 bytes, end mark), some noise
    task automatic queue_random_traffic(input int n);
        int queued;
        int bytes;
        int k;
        queued = 0;
        while (queued < n)
        begin
            if ($urandom_range(99) < 75)
            begin
                bytes = $urandom_range(6);
                queue_item(KIND_HEADER, 16'($urandom), 8'($urandom), bytes == 0);
                for (k = 0; k < bytes; k++)
                    queue_item(KIND_DATA, 16'($urandom), 8'($urandom), k == bytes - 1);
                queued += bytes + 1;
            end
            else
            begin
                queue_item(1'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
                queued++;
            end
        end
    endtask

    // Wait until all items are taken and every expected pair has come out
    task automatic drain();
        while (frames_to_send.size() != 0 || frame_in_bus.valid
               || expected_pairs.size() != 0)
            @(posedge clk);
    endtask

    task automatic note_mismatch(input string what, input chip_pair_t want,
                                 input chip_pair_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s: exp f=%b s=%b l=%b d=%b, got f=%b s=%b l=%b d=%b",
                     $realtime, what, want.first_chip, want.second_chip, want.run_last,
                     want.telegram_done, got.first_chip, got.second_chip, got.run_last,
                     got.telegram_done);
    endtask

    // Driver: offers items from the pending queue, predicts on each transfer
    always @(posedge clk)
    begin
        frame_item_t nxt;
        frame_item_t taken;
        if (rst_n)
        begin
            if (frame_in_bus.valid && frame_in_bus.ready)
            begin
                taken.kind          = frame_in_bus.kind;
                taken.sensor_id     = frame_in_bus.sensor_id;
                taken.payload_byte  = frame_in_bus.payload_byte;
                taken.ends_telegram = frame_in_bus.ends_telegram;
                frame_telegram_item(taken);
                items_accepted++;
                if (taken.kind == KIND_HEADER)
                    headers_accepted++;
            end
            if (!frame_in_bus.valid || frame_in_bus.ready)
            begin
                if (frames_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = frames_to_send.pop_front();
                    frame_in_bus.valid         <= 1'b1;
                    frame_in_bus.kind          <= nxt.kind;
                    frame_in_bus.sensor_id     <= nxt.sensor_id;
                    frame_in_bus.payload_byte  <= nxt.payload_byte;
                    frame_in_bus.ends_telegram <= nxt.ends_telegram;
                end
                else
                begin
                    frame_in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready: long hold-off when requested, random stalls otherwise
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                pair_out_bus.ready <= 1'b0;
                hold_left = hold_left - 1;
            end
            else
            begin
                pair_out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Monitor: compare each pair transfer with the oldest expectation
    always @(posedge clk)
    begin
        chip_pair_t got;
        chip_pair_t want;
        if (rst_n && pair_out_bus.valid && pair_out_bus.ready)
        begin
            got.first_chip    = pair_out_bus.first_chip;
            got.second_chip   = pair_out_bus.second_chip;
            got.run_last      = pair_out_bus.run_last;
            got.telegram_done = pair_out_bus.telegram_done;
            if (expected_pairs.size() == 0)
            begin
                note_mismatch("unexpected chip pair", 'x, got);
            end
            else
            begin
                want = expected_pairs.pop_front();
                pairs_checked++;
                if (want.telegram_done)
                    telegrams_done++;
                if (got.first_chip !== want.first_chip
                    || got.second_chip !== want.second_chip
                    || got.run_last !== want.run_last
                    || got.telegram_done !== want.telegram_done)
                    note_mismatch("chip pair mismatch", want, got);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d pairs still expected",
                     cycle_count, expected_pairs.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus sequence
    initial
    begin
        int phase_send [4];
        int phase_recv [4];
        int ph;
        phase_send = '{0, 65, 0, 10};
        phase_recv = '{0, 0, 65, 10};

        rst_n = 1'b0;
        frame_in_bus.valid         = 1'b0;
        frame_in_bus.kind          = KIND_HEADER;
        frame_in_bus.sensor_id     = '0;
        frame_in_bus.payload_byte  = '0;
        frame_in_bus.ends_telegram = 1'b0;
        pair_out_bus.ready         = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: data with no header first, field extremes, unused fields,
        // header-only telegram, data after an end mark
        queue_item(KIND_DATA,   16'h0000, 8'hA5, 1'b0);
        queue_item(KIND_HEADER, 16'h0000, 8'hFF, 1'b0);
        queue_item(KIND_DATA,   16'hFFFF, 8'h00, 1'b0);
        queue_item(KIND_DATA,   16'h1234, 8'hFF, 1'b1);
        queue_item(KIND_HEADER, 16'hFFFF, 8'h00, 1'b1);
        queue_item(KIND_HEADER, 16'hA55A, 8'h5A, 1'b0);
        queue_item(KIND_DATA,   16'h0000, 8'h80, 1'b0);
        queue_item(KIND_DATA,   16'h0000, 8'h01, 1'b1);
        queue_item(KIND_DATA,   16'hFFFF, 8'h3C, 1'b1);
        queue_item(KIND_HEADER, 16'h8001, 8'h00, 1'b0);
        queue_item(KIND_DATA,   16'h0000, 8'h7E, 1'b1);
        queue_item(KIND_HEADER, 16'h5AA5, 8'hC3, 1'b1);
        drain();

        // Random phases with different idle and stall rates
        for (ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = phase_send[ph];
            recv_stall_pct = phase_recv[ph];
            queue_random_traffic(50);
            // sender holds back until the block has emptied
            drain();
            queue_random_traffic(50);
            drain();
        end

        // Receiver holds off while the sender keeps offering, input backs up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random_traffic(24);
        hold_left = HOLD_OFF_CYCLES;
        drain();

        // Tail: any extra pair shows up as unexpected
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d frame items (%0d headers, %0d data bytes) under varied idling",
                 items_accepted, headers_accepted, items_accepted - headers_accepted);
        $display("Checked %0d chip pairs over %0d ended telegrams, %0d mismatches",
                 pairs_checked, telegrams_done, mismatches);
        if (mismatches == 0 && expected_pairs.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
